// ===== rtl/ptd_pkg.sv =====
// ptd_pkg: shared types and constants of the provider task dispatcher
// item, result, provider entry and queue slot layouts, mode/status codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ptd_pkg;

	localparam int NUM_PROVIDERS = 8;
	localparam int QUEUE_SLOTS   = 2;
	localparam int IDX_W         = $clog2(NUM_PROVIDERS);
	localparam int SLOT_AW       = IDX_W + $clog2(QUEUE_SLOTS);
	localparam int CFG_W         = 4;

	localparam logic [1:0] MODE_LOAD     = 2'd0;
	localparam logic [1:0] MODE_SUBMIT   = 2'd1;
	localparam logic [1:0] MODE_COMPLETE = 2'd2;

	localparam logic [1:0] PREF_CHEAP     = 2'd0;
	localparam logic [1:0] PREF_FAST      = 2'd1;
	localparam logic [1:0] PREF_FIRST_IDLE = 2'd2;

	localparam logic [2:0] ST_ASSIGNED  = 3'd0;
	localparam logic [2:0] ST_REJECTED  = 3'd1;
	localparam logic [2:0] ST_COMPLETED = 3'd2;
	localparam logic [2:0] ST_EMPTY     = 3'd3;
	localparam logic [2:0] ST_LOADED    = 3'd4;

	localparam logic [1:0] FILL_EMPTY = 2'd0;
	localparam logic [1:0] FILL_HALF  = 2'd1;
	localparam logic [1:0] FILL_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]         mode;
		logic [2:0]         provider_index;
		logic [15:0]        price_value;
		logic [15:0]        perf_value;
		logic [1:0]         preference;
		logic signed [15:0] task_degree;
		logic [15:0]        client_tag;
	} item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [2:0]         chosen_provider;
		logic signed [15:0] done_degree;
		logic [15:0]        done_client;
		logic [1:0]         queue_fill;
	} result_t;

	typedef struct packed {
		logic [15:0] price;
		logic [15:0] perf;
		logic [1:0]  count;
		logic        head;
		logic        tail;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{price: 16'd0, perf: 16'd0, count: FILL_EMPTY,
		head: 1'b0, tail: 1'b1};

	typedef struct packed {
		logic signed [15:0] degree;
		logic [15:0]        client;
	} slot_t;

	typedef struct packed {
		logic             clear;
		logic             update;
		logic [1:0]       pref;
		logic [IDX_W-1:0] index;
	} sel_ctl_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] index;
	} sel_res_t;

endpackage

`default_nettype wire

// ===== rtl/ptd_select.sv =====
// ptd_select: running provider selection over entries read one per cycle
// tracks preference best, last idle and last half-full provider
// depends on ptd_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptd_select (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ptd_pkg::sel_ctl_t ctl,
	input  wire ptd_pkg::entry_t   ent,
	output ptd_pkg::sel_res_t      res
);

	logic                      pref_found_q;
	logic                      idle_found_q;
	logic                      half_found_q;
	logic [ptd_pkg::IDX_W-1:0] best_idx_q;
	logic [ptd_pkg::IDX_W-1:0] idle_idx_q;
	logic [ptd_pkg::IDX_W-1:0] half_idx_q;
	logic [15:0]               best_key_q;
	logic [15:0]               key;
	logic                      better;
	logic                      has_room;
	logic                      is_first;
	logic                      take_pref;

	always_comb begin
		key      = (ctl.pref == ptd_pkg::PREF_CHEAP) ? ent.price : ent.perf;
		better   = (ctl.pref == ptd_pkg::PREF_CHEAP) ? (key < best_key_q) : (key > best_key_q);
		has_room = ent.count < ptd_pkg::FILL_FULL;
		is_first = ctl.index == '0;
		case (ctl.pref)
			ptd_pkg::PREF_CHEAP, ptd_pkg::PREF_FAST: begin
				take_pref = !is_first && better && has_room;
			end
			ptd_pkg::PREF_FIRST_IDLE: begin
				take_pref = !pref_found_q && (ent.count == ptd_pkg::FILL_EMPTY);
			end
			default: begin
				take_pref = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pref_found_q <= 1'b0;
			idle_found_q <= 1'b0;
			half_found_q <= 1'b0;
		end else if (ctl.clear) begin
			pref_found_q <= 1'b0;
			idle_found_q <= 1'b0;
			half_found_q <= 1'b0;
		end else if (ctl.update) begin
			if (take_pref) begin
				pref_found_q <= 1'b1;
			end
			if (ent.count == ptd_pkg::FILL_EMPTY) begin
				idle_found_q <= 1'b1;
			end
			if (ent.count == ptd_pkg::FILL_HALF) begin
				half_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.update) begin
			if (is_first || take_pref) begin
				best_idx_q <= ctl.index;
				best_key_q <= key;
			end
			if (ent.count == ptd_pkg::FILL_EMPTY) begin
				idle_idx_q <= ctl.index;
			end
			if (ent.count == ptd_pkg::FILL_HALF) begin
				half_idx_q <= ctl.index;
			end
		end
	end

	always_comb begin
		res.found = pref_found_q || idle_found_q || half_found_q;
		if (pref_found_q) begin
			res.index = best_idx_q;
		end else if (idle_found_q) begin
			res.index = idle_idx_q;
		end else begin
			res.index = half_idx_q;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/provider_task_dispatcher_core.sv =====
// provider_task_dispatcher_core: top level, provider table and queue slot memories
// sequencer for load, submit and complete items
// depends on ptd_pkg, ptd_select
//
// channel   | ports                          | handshake
// item      | start, busy, item              | taken when start and not busy
// result    | result_valid, result           | one-cycle strobe, no back-pressure
// config    | cfg_wr_en, cfg_wr_data         | written on any edge with cfg_wr_en
//
// load: result after S_LOAD; complete: S_CRD, S_CSLOT, S_CDONE unless entry empty
// submit: S_SCAN over active providers, then S_DRAIN rejects or S_PICK assigns
// one provider table read per scan cycle
// busy stays high until the result strobe is issued; mode 3 is dropped, no result
// reset clears the provider table through per-entry valid bits, no sweep
// queue slots hold no reset value
`timescale 1ns / 1ps
`default_nettype none

module provider_task_dispatcher_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire ptd_pkg::item_t            item,
	output logic                           result_valid,
	output ptd_pkg::result_t               result,
	input  wire logic                      cfg_wr_en,
	input  wire logic [ptd_pkg::CFG_W-1:0] cfg_wr_data
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOAD  = 3'd1;
	localparam logic [2:0] S_CRD   = 3'd2;
	localparam logic [2:0] S_CSLOT = 3'd3;
	localparam logic [2:0] S_CDONE = 3'd4;
	localparam logic [2:0] S_SCAN  = 3'd5;
	localparam logic [2:0] S_DRAIN = 3'd6;
	localparam logic [2:0] S_PICK  = 3'd7;

	localparam logic [ptd_pkg::CFG_W-1:0] CFG_MAX = ptd_pkg::CFG_W'(ptd_pkg::NUM_PROVIDERS);

	logic [2:0]                state_q;
	logic [2:0]                state_d;
	logic                      decide_q;
	logic                      decide_d;
	logic [ptd_pkg::CFG_W-1:0] cfg_q;
	ptd_pkg::item_t            item_q;
	logic [ptd_pkg::IDX_W-1:0] scan_q;
	logic [ptd_pkg::IDX_W-1:0] last_idx;
	logic [ptd_pkg::IDX_W-1:0] pick_q;
	logic                      rd_vld_s1;
	logic [ptd_pkg::IDX_W-1:0] rd_idx_s1;
	logic                      accept;

	ptd_pkg::entry_t           ent_mem [ptd_pkg::NUM_PROVIDERS];
	logic [ptd_pkg::NUM_PROVIDERS-1:0] ent_vld_q;
	ptd_pkg::entry_t           ent_rd_q;
	logic                      ent_re;
	logic [ptd_pkg::IDX_W-1:0] ent_ra;
	logic                      ent_we;
	logic [ptd_pkg::IDX_W-1:0] ent_wa;
	ptd_pkg::entry_t           ent_wd;

	ptd_pkg::slot_t              slot_mem [ptd_pkg::NUM_PROVIDERS*ptd_pkg::QUEUE_SLOTS];
	ptd_pkg::slot_t              slot_rd_q;
	logic                        slot_re;
	logic [ptd_pkg::SLOT_AW-1:0] slot_ra;
	logic                        slot_we;
	logic [ptd_pkg::SLOT_AW-1:0] slot_wa;
	ptd_pkg::slot_t              slot_wd;

	logic                      emit;
	ptd_pkg::result_t          emit_data;
	ptd_pkg::sel_ctl_t         sel_ctl;
	ptd_pkg::sel_res_t         sel_res;

	assign busy   = state_q != S_IDLE;
	assign accept = start && !busy;

	always_comb begin
		if (cfg_q == '0) begin
			last_idx = '0;
		end else if (cfg_q > CFG_MAX) begin
			last_idx = ptd_pkg::IDX_W'(ptd_pkg::NUM_PROVIDERS - 1);
		end else begin
			last_idx = ptd_pkg::IDX_W'(cfg_q - 1'b1);
		end
	end

	always_comb begin
		sel_ctl.clear  = accept;
		sel_ctl.update = rd_vld_s1;
		sel_ctl.pref   = item_q.preference;
		sel_ctl.index  = rd_idx_s1;
	end

	ptd_select u_select (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sel_ctl),
		.ent    (ent_rd_q),
		.res    (sel_res)
	);

	always_comb begin
		state_d   = state_q;
		decide_d  = 1'b0;
		ent_re    = 1'b0;
		ent_ra    = item_q.provider_index;
		ent_we    = 1'b0;
		ent_wa    = item_q.provider_index;
		ent_wd    = ent_rd_q;
		slot_re   = 1'b0;
		slot_ra   = {item_q.provider_index, ent_rd_q.head};
		slot_we   = 1'b0;
		slot_wa   = {pick_q, ~ent_rd_q.tail};
		slot_wd   = '{degree: item_q.task_degree, client: item_q.client_tag};
		emit      = 1'b0;
		emit_data = '{status: ptd_pkg::ST_LOADED, chosen_provider: item_q.provider_index,
			done_degree: 16'sd0, done_client: 16'd0, queue_fill: ptd_pkg::FILL_EMPTY};
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (item.mode)
						ptd_pkg::MODE_LOAD:     state_d = S_LOAD;
						ptd_pkg::MODE_COMPLETE: state_d = S_CRD;
						ptd_pkg::MODE_SUBMIT:   state_d = S_SCAN;
						default:                state_d = S_IDLE;
					endcase
				end
			end
			S_LOAD: begin
				ent_we = 1'b1;
				ent_wd = '{price: item_q.price_value, perf: item_q.perf_value,
					count: ptd_pkg::FILL_EMPTY, head: 1'b0, tail: 1'b1};
				emit    = 1'b1;
				state_d = S_IDLE;
			end
			S_CRD: begin
				ent_re  = 1'b1;
				state_d = S_CSLOT;
			end
			S_CSLOT: begin
				if (ent_rd_q.count == ptd_pkg::FILL_EMPTY) begin
					emit             = 1'b1;
					emit_data.status = ptd_pkg::ST_EMPTY;
					state_d          = S_IDLE;
				end else begin
					slot_re      = 1'b1;
					ent_we       = 1'b1;
					ent_wd.count = ent_rd_q.count - 1'b1;
					ent_wd.head  = ~ent_rd_q.head;
					state_d      = S_CDONE;
				end
			end
			S_CDONE: begin
				emit                  = 1'b1;
				emit_data.status      = ptd_pkg::ST_COMPLETED;
				emit_data.done_degree = slot_rd_q.degree;
				emit_data.done_client = slot_rd_q.client;
				emit_data.queue_fill  = ent_rd_q.count - 1'b1;
				state_d               = S_IDLE;
			end
			S_SCAN: begin
				ent_re = 1'b1;
				ent_ra = scan_q;
				if (scan_q == last_idx) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (decide_q) begin
					if (!sel_res.found) begin
						emit                          = 1'b1;
						emit_data.status              = ptd_pkg::ST_REJECTED;
						emit_data.chosen_provider     = '0;
						state_d                       = S_IDLE;
					end else begin
						ent_re  = 1'b1;
						ent_ra  = sel_res.index;
						state_d = S_PICK;
					end
				end else begin
					decide_d = 1'b1;
				end
			end
			S_PICK: begin
				ent_we                    = 1'b1;
				ent_wa                    = pick_q;
				ent_wd.count              = ent_rd_q.count + 1'b1;
				ent_wd.tail               = ~ent_rd_q.tail;
				slot_we                   = 1'b1;
				emit                      = 1'b1;
				emit_data.status          = ptd_pkg::ST_ASSIGNED;
				emit_data.chosen_provider = pick_q;
				emit_data.queue_fill      = ent_rd_q.count + 1'b1;
				state_d                   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			decide_q     <= 1'b0;
			cfg_q        <= ptd_pkg::CFG_W'(1);
			rd_vld_s1    <= 1'b0;
			result_valid <= 1'b0;
			ent_vld_q    <= '0;
		end else begin
			state_q      <= state_d;
			decide_q     <= decide_d;
			rd_vld_s1    <= (state_q == S_SCAN);
			result_valid <= emit;
			if (cfg_wr_en) begin
				cfg_q <= cfg_wr_data;
			end
			if (ent_we) begin
				ent_vld_q[ent_wa] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
			scan_q <= '0;
		end else if (state_q == S_SCAN) begin
			scan_q <= scan_q + 1'b1;
		end
		rd_idx_s1 <= scan_q;
		if (state_q == S_DRAIN) begin
			pick_q <= sel_res.index;
		end
		if (emit) begin
			result <= emit_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_wa] <= ent_wd;
		end
		if (ent_re) begin
			ent_rd_q <= ent_vld_q[ent_ra] ? ent_mem[ent_ra] : ptd_pkg::ENTRY_RESET;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_wa] <= slot_wd;
		end
		if (slot_re) begin
			slot_rd_q <= slot_mem[slot_ra];
		end
	end

`ifndef NO_ASSERTIONS
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result strobe without an item in flight");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == ptd_pkg::ST_REJECTED) |->
		(result.chosen_provider == '0) && (result.queue_fill == ptd_pkg::FILL_EMPTY))
		else $error("rejected item carries provider or fill");

	a_assign_fill: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == ptd_pkg::ST_ASSIGNED) |->
		(result.queue_fill == ptd_pkg::FILL_HALF) || (result.queue_fill == ptd_pkg::FILL_FULL))
		else $error("assigned item with impossible queue fill");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(ent_we || slot_we) |-> busy)
		else $error("memory write while idle");
`endif

endmodule

`default_nettype wire
